// File: rtl/rave_pkg.sv
// Shared types and constants of the rotor angle and velocity estimator.
// Used by rave_ctrl and rotor_angle_velocity_estimator_top.
// Depends on nothing.
package rave_pkg;

  // Default resolution of one mechanical turn in bits.
  localparam int unsigned ANGLE_BITS_DEF = 14;

  // Fixed field and register widths.
  localparam int unsigned DT_W      = 24;
  localparam int unsigned OFFSET_W  = 14;
  localparam int unsigned POLE_W    = 7;
  localparam int unsigned ALPHA_W   = 17;
  localparam int unsigned CFG_W     = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SPEED_W   = 32;
  localparam int unsigned FILT_W    = 48;   // Q32.16 filter state
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned ACC_W     = 66;   // width of the shared adder
  localparam int unsigned USEC_W    = 20;

  localparam logic [ALPHA_W-1:0] Q16_ONE       = 17'h10000;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET   = 17'd13107;
  localparam logic [POLE_W-1:0]  POLE_RESET    = 7'd1;
  localparam logic [USEC_W-1:0]  US_PER_S      = 20'd1000000;
  localparam logic [FILT_W-1:0]  VSAT_POS      = 48'h7FFF_FFFF_FFFF;
  localparam logic [FILT_W-1:0]  VSAT_NEG      = 48'h8000_0000_0000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE_OFFSET = 2'd0,
    CFG_POLE_PAIRS   = 2'd1,
    CFG_FILTER_ALPHA = 2'd2
  } rave_cfg_idx_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIV,
    ST_VRAW,
    ST_DELTA,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } rave_state_e;

  // Step enables from the sequencer to the datapath.
  typedef struct packed {
    logic idle;
    logic scale;
    logic div;
    logic vraw;
    logic delta;
    logic mul;
    logic acc;
    logic out_load;
  } rave_ctl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic dt_zero;
    logic out_free;
  } rave_sts_t;

endpackage

// File: rtl/rave_addsub.sv
// Shared wide adder/subtractor of the estimator, with carry out.
// Depends on nothing; instantiated by rotor_angle_velocity_estimator_top.
module rave_addsub #(
  parameter int unsigned W = 66
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] sum_o,
  output logic         carry_o
);

  logic [W-1:0] b_op;

  // A subtract adds the inverted operand plus one; carry set means a >= b.
  assign b_op = sub_i ? ~b_i : b_i;
  assign {carry_o, sum_o} = {1'b0, a_i} + {1'b0, b_op} + (W + 1)'(sub_i);

endmodule

// File: rtl/rave_ctrl.sv
// Sequencer of the estimator: state machine and step counter.
// Depends on rave_pkg; instantiated by rotor_angle_velocity_estimator_top.
module rave_ctrl #(
  parameter int unsigned NUM_W = 49
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  rave_pkg::rave_sts_t sts_i,
  output rave_pkg::rave_ctl_t ctl_o
);
  import rave_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W);

  rave_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic cnt_zero;

  assign cnt_zero = (cnt_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_SCALE;
      ST_SCALE: state_d = sts_i.dt_zero ? ST_VRAW : ST_DIV;
      ST_DIV:   if (cnt_zero) state_d = ST_VRAW;
      ST_VRAW:  state_d = ST_DELTA;
      ST_DELTA: state_d = ST_MUL;
      ST_MUL:   if (cnt_zero) state_d = ST_ACC;
      ST_ACC:   state_d = ST_OUT;
      ST_OUT:   if (sts_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // One quotient bit per divide step, one coefficient bit per multiply step.
  always_comb begin
    cnt_d = cnt_q;
    case (state_q)
      ST_SCALE: cnt_d = CNT_W'(NUM_W - 1);
      ST_DELTA: cnt_d = CNT_W'(ALPHA_W - 1);
      ST_DIV, ST_MUL: if (!cnt_zero) cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    unique case (state_q)
      ST_IDLE:  ctl_o.idle     = 1'b1;
      ST_SCALE: ctl_o.scale    = 1'b1;
      ST_DIV:   ctl_o.div      = 1'b1;
      ST_VRAW:  ctl_o.vraw     = 1'b1;
      ST_DELTA: ctl_o.delta    = 1'b1;
      ST_MUL:   ctl_o.mul      = 1'b1;
      ST_ACC:   ctl_o.acc      = 1'b1;
      ST_OUT:   ctl_o.out_load = sts_i.out_free;
      default:  ctl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: rtl/rotor_angle_velocity_estimator_top.sv
// Top level of the rotor angle and velocity estimator: datapath and ports.
// Depends on rave_pkg, rave_addsub and rave_ctrl.
//
// Each request carries a raw sensor angle and the microseconds since the
// previous sample. The block returns one result per request: the mechanical
// angle (raw angle minus the calibrated offset, modulo one turn), the
// electrical angle (mechanical angle times the pole pairs, modulo one turn)
// and the filtered speed in angle counts per second, saturated to 32 bits.
// One turn is 2^ANGLE_BITS counts. The speed is the shortest wrapped angle
// step scaled by 10^6 * 2^16 and divided by the elapsed time, then run
// through a first-order low-pass filter with Q16 coefficient filter_alpha.
// A zero elapsed time counts as zero raw speed, and the filter still runs.
// The block works on one request at a time. An accepted request runs the
// scale, divide, raw speed, delta, multiply, accumulate and output steps;
// the divide is skipped when the elapsed time is zero, and the output step
// waits until the result register is free. Ready rises at the edge that
// loads the result, and the next request can be accepted from that edge
// on. Nearly all of a run with nonzero elapsed time is the radix-2 restoring
// divider, which yields one quotient bit per cycle over ANGLE_BITS + 35
// bits, followed by a 17-step shift-and-add filter multiply. Both run on
// one shared 66-bit adder. A finished result waits in its own register, so
// the next request is accepted while the sink still stalls; the result of
// that request then waits in the sequencer until the register is free.
// Configuration writes take effect at once and must be made only while the
// block is idle.
module rotor_angle_velocity_estimator_top #(
  parameter int unsigned ANGLE_BITS = rave_pkg::ANGLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write port.
  input  logic                                  cfg_we_i,
  input  logic [rave_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [rave_pkg::CFG_W-1:0]            cfg_data_i,
  // Input requests.
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // From bit 0: raw_angle (ANGLE_BITS), elapsed_us (24), zero fill.
  input  logic [((ANGLE_BITS+rave_pkg::DT_W+7)/8)*8-1:0] s_axis_tdata_i,
  // Results.
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // From bit 0: mech_angle (ANGLE_BITS), elec_angle (ANGLE_BITS),
  // speed (32, signed), zero fill.
  output logic [((2*ANGLE_BITS+rave_pkg::SPEED_W+7)/8)*8-1:0] m_axis_tdata_o
);
  import rave_pkg::*;

  localparam int unsigned OUT_TW = ((2 * ANGLE_BITS + SPEED_W + 7) / 8) * 8;
  // The angle step magnitude is at most half a turn, so the step times
  // 10^6 fits in ANGLE_BITS + 19 bits; the dividend carries 16 more bits.
  localparam int unsigned PROD_W = ANGLE_BITS + 19;
  localparam int unsigned NUM_W  = PROD_W + FRAC_W;
  localparam int unsigned QX_W   = (NUM_W > FILT_W) ? NUM_W : FILT_W;
  localparam logic [ANGLE_BITS-1:0] HALF_TURN = {1'b1, {(ANGLE_BITS-1){1'b0}}};

  rave_ctl_t ctl;
  rave_sts_t sts;

  // Configuration registers.
  logic [OFFSET_W-1:0] offset_q;
  logic [POLE_W-1:0]   pole_q;
  logic [ALPHA_W-1:0]  alpha_q;

  // Estimator state.
  logic [ANGLE_BITS-1:0] last_q;
  logic [FILT_W-1:0]     filt_q;

  // Working registers of one request.
  logic [ANGLE_BITS-1:0] mech_q, elec_q, mag_q;
  logic                  neg_q;
  logic [DT_W-1:0]       dt_q;
  logic [NUM_W-1:0]      num_q;     // dividend, shifted out as quotient comes in
  logic [DT_W-1:0]       rem_q;
  logic [ACC_W-1:0]      mc_q;      // multiplicand, shifted left per step
  logic [ACC_W-1:0]      acc_q;
  logic [ALPHA_W-1:0]    ash_q;     // coefficient, shifted right per step

  // Result register.
  logic                  out_valid_q;
  logic [ANGLE_BITS-1:0] out_mech_q, out_elec_q;
  logic [SPEED_W-1:0]    out_speed_q;

  // Input decode.
  logic                  accept;
  logic [ANGLE_BITS-1:0] raw_c, mech_c, step_c, mag_c;
  logic [DT_W-1:0]       dt_c;
  logic                  neg_c;
  logic [ANGLE_BITS+POLE_W-1:0] elec_full;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign raw_c  = s_axis_tdata_i[ANGLE_BITS-1:0];
  assign dt_c   = s_axis_tdata_i[ANGLE_BITS+DT_W-1:ANGLE_BITS];
  assign mech_c = raw_c - ANGLE_BITS'(offset_q);
  assign elec_full = (ANGLE_BITS + POLE_W)'(mech_c) * (ANGLE_BITS + POLE_W)'(pole_q);

  // The wrapped step lands in one half turn; a step of exactly half a turn
  // keeps the sign of the unwrapped difference.
  assign step_c = mech_c - last_q;
  assign neg_c  = (step_c == HALF_TURN) ? (mech_c < last_q) : step_c[ANGLE_BITS-1];
  assign mag_c  = neg_c ? (~step_c + ANGLE_BITS'(1)) : step_c;

  // Dividend: |step| * 10^6 * 2^16.
  logic [ANGLE_BITS+USEC_W-1:0] prod_c;
  assign prod_c = (ANGLE_BITS + USEC_W)'(mag_q) * (ANGLE_BITS + USEC_W)'(US_PER_S);

  // Quotient saturation to the Q32.16 range.
  logic [QX_W-1:0]   qx;
  logic [FILT_W-1:0] qsat;
  assign qx = QX_W'(num_q);
  always_comb begin
    if (neg_q) begin
      qsat = (qx > QX_W'(VSAT_NEG)) ? VSAT_NEG : qx[FILT_W-1:0];
    end else begin
      qsat = (qx > QX_W'(VSAT_POS)) ? VSAT_POS : qx[FILT_W-1:0];
    end
  end

  logic [ALPHA_W-1:0] alpha_cl;
  assign alpha_cl = (alpha_q > Q16_ONE) ? Q16_ONE : alpha_q;

  logic [ACC_W-1:0] filt_ext;
  assign filt_ext = {{(ACC_W-FILT_W){filt_q[FILT_W-1]}}, filt_q};

  // Shared adder operand selection.
  logic [DT_W:0]    div_rem;
  logic [ACC_W-1:0] op_a, op_b, add_sum;
  logic             op_sub, add_carry;

  assign div_rem = {rem_q, num_q[NUM_W-1]};

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    if (ctl.div) begin
      op_a   = ACC_W'(div_rem);
      op_b   = ACC_W'(dt_q);
      op_sub = 1'b1;
    end else if (ctl.vraw) begin
      op_b   = ACC_W'(qsat);
      op_sub = neg_q;
    end else if (ctl.delta) begin
      op_a   = mc_q;
      op_b   = filt_ext;
      op_sub = 1'b1;
    end else if (ctl.mul) begin
      op_a   = acc_q;
      op_b   = ash_q[0] ? mc_q : '0;
    end else if (ctl.acc) begin
      op_a   = acc_q;
      op_b   = filt_ext << FRAC_W;
    end
  end

  rave_addsub #(
    .W(ACC_W)
  ) u_addsub (
    .a_i    (op_a),
    .b_i    (op_b),
    .sub_i  (op_sub),
    .sum_o  (add_sum),
    .carry_o(add_carry)
  );

  assign sts.dt_zero  = (dt_q == '0);
  assign sts.out_free = !out_valid_q || m_axis_tready_i;

  rave_ctrl #(
    .NUM_W(NUM_W)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  assign s_axis_tready_o = ctl.idle;

  // Configuration, estimator state and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      pole_q      <= POLE_RESET;
      alpha_q     <= ALPHA_RESET;
      last_q      <= '0;
      filt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ANGLE_OFFSET: offset_q <= cfg_data_i[OFFSET_W-1:0];
          CFG_POLE_PAIRS:   pole_q   <= cfg_data_i[POLE_W-1:0];
          CFG_FILTER_ALPHA: alpha_q  <= cfg_data_i[ALPHA_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        last_q <= mech_c;
      end
      // The sum always fits 64 bits; its floor by 2^16 is the new state.
      if (ctl.acc) begin
        filt_q <= add_sum[FILT_W+FRAC_W-1:FRAC_W];
      end
      if (ctl.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mech_q <= mech_c;
      elec_q <= elec_full[ANGLE_BITS-1:0];
      mag_q  <= mag_c;
      neg_q  <= neg_c;
      dt_q   <= dt_c;
    end
    if (ctl.scale) begin
      num_q <= sts.dt_zero ? '0 : {prod_c[PROD_W-1:0], {FRAC_W{1'b0}}};
      rem_q <= '0;
    end
    // Restoring divide step: keep the difference when it did not borrow.
    if (ctl.div) begin
      rem_q <= add_carry ? add_sum[DT_W-1:0] : div_rem[DT_W-1:0];
      num_q <= {num_q[NUM_W-2:0], add_carry};
    end
    if (ctl.vraw) begin
      mc_q <= add_sum;
    end
    // Filter as filt * 2^16 + alpha * (raw - filt).
    if (ctl.delta) begin
      mc_q  <= add_sum;
      acc_q <= '0;
      ash_q <= alpha_cl;
    end
    if (ctl.mul) begin
      acc_q <= add_sum;
      mc_q  <= mc_q << 1;
      ash_q <= ash_q >> 1;
    end
    if (ctl.out_load) begin
      out_mech_q  <= mech_q;
      out_elec_q  <= elec_q;
      out_speed_q <= filt_q[FILT_W-1:FRAC_W];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TW'({out_speed_q, out_elec_q, out_mech_q});

  // A request starts a run, so the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready_o)
    else $error("input accepted again right after a request");

  // A new result never overwrites one that the sink has not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.out_load |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result register overwritten while held");

  // The filter sum stays within 64 signed bits.
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.acc |-> (add_sum[ACC_W-1:ACC_W-3] == 3'b000 ||
                 add_sum[ACC_W-1:ACC_W-3] == 3'b111))
    else $error("filter sum out of range");

endmodule
